@@ hdl/lfps_pkg.sv @@
// Shared types, constants and position lookup for the line follower PD steering block.
`timescale 1ns / 1ps

package lfps_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_W     = 16;
   localparam int POS_W      = 4;
   localparam int LINE_W     = 4;

   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [GAIN_W-1:0]     gain_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [LINE_W-1:0]     line_type;

   // configuration register indexes
   localparam csr_idx_type CSR_BASE_SPEED = 2'd0;
   localparam csr_idx_type CSR_PROP_GAIN  = 2'd1;
   localparam csr_idx_type CSR_DERIV_GAIN = 2'd2;
   localparam csr_idx_type CSR_PWM_MAX    = 2'd3;

   localparam logic [15:0] RST_BASE_SPEED = 16'd265;
   localparam gain_type    RST_PROP_GAIN  = 16'd3840;
   localparam gain_type    RST_DERIV_GAIN = 16'd794;
   localparam logic [15:0] RST_PWM_MAX    = 16'd399;

   // fixed motor pairs
   localparam logic [15:0] PWM_VEER_LOW  = 16'd230;
   localparam logic [15:0] PWM_VEER_HIGH = 16'd290;
   localparam logic [15:0] PWM_STRAIGHT  = 16'd260;

   typedef enum logic [1:0] {
      MODE_PD       = 2'd0,
      MODE_VEER_A   = 2'd1,
      MODE_VEER_B   = 2'd2,
      MODE_STRAIGHT = 2'd3
   } steer_mode_type;

   // line sensor patterns
   localparam line_type PAT_CENTER   = 4'b0110;
   localparam line_type PAT_LEFT_1   = 4'b0100;
   localparam line_type PAT_RIGHT_1  = 4'b0010;
   localparam line_type PAT_LEFT_3   = 4'b1100;
   localparam line_type PAT_RIGHT_3  = 4'b0011;
   localparam line_type PAT_LEFT_4   = 4'b1110;
   localparam line_type PAT_RIGHT_4  = 4'b0111;
   localparam line_type PAT_LEFT_6   = 4'b1000;
   localparam line_type PAT_RIGHT_6  = 4'b0001;

   // unknown patterns keep the previous position
   function automatic pos_type map_position(line_type bits, logic hold, pos_type keep);
      pos_type pos;
      case (bits)
         PAT_CENTER:  pos = 4'sd0;
         PAT_LEFT_1:  pos = 4'sd1;
         PAT_RIGHT_1: pos = -4'sd1;
         PAT_LEFT_3:  pos = 4'sd3;
         PAT_RIGHT_3: pos = hold ? 4'sd0 : -4'sd3;
         PAT_LEFT_4:  pos = 4'sd4;
         PAT_RIGHT_4: pos = hold ? 4'sd0 : -4'sd4;
         PAT_LEFT_6:  pos = 4'sd6;
         PAT_RIGHT_6: pos = -4'sd6;
         default:     pos = keep;
      endcase
      return pos;
   endfunction

endpackage

@@ hdl/lfps_if.sv @@
// Handshake channel interfaces for sensor items, motor results and register writes.
`timescale 1ns / 1ps

interface lfps_req_if
   import lfps_pkg::*;
();
   logic     valid;
   logic     ready;
   line_type line_bits;
   logic     side_sensor_a;
   logic     side_sensor_b;
   logic     junction_hold;

   modport source (output valid, line_bits, side_sensor_a, side_sensor_b, junction_hold,
                   input ready);
   modport sink   (input valid, line_bits, side_sensor_a, side_sensor_b, junction_hold,
                   output ready);
endinterface

interface lfps_rsp_if #(
   parameter int PWM_BITS = 10
);
   logic                valid;
   logic                ready;
   logic [PWM_BITS-1:0] motor_a_pwm;
   logic [PWM_BITS-1:0] motor_b_pwm;
   logic [1:0]          steer_mode;

   modport source (output valid, motor_a_pwm, motor_b_pwm, steer_mode, input ready);
   modport sink   (input valid, motor_a_pwm, motor_b_pwm, steer_mode, output ready);
endinterface

interface lfps_csr_if
   import lfps_pkg::*;
();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/line_follower_pd_steering_top.sv @@
// Line follower PD steering: sample register, PD motor math or fixed motor pairs, result register.
// An accepted item is held in the sample register and then in the result register,
// from which rsp takes it; a stall on rsp ready can hold it in either register.
// Throughput: one item per cycle; an input register and a result register
// separate the two channels, so a full pipeline stalls only on rsp ready.
// Reset (synchronous, active high) empties both stages, clears the stored
// position and loads the default gains, base speed and pwm limit.
`timescale 1ns / 1ps

module line_follower_pd_steering_top
   import lfps_pkg::*;
#(
   parameter int PWM_BITS = 10
) (
   input logic      clock,
   input logic      reset,
   lfps_req_if.sink req_if,
   lfps_rsp_if.source rsp_if,
   lfps_csr_if.sink csr_if
);

   localparam int CTL_W = 23;
   localparam int SUM_W = ((PWM_BITS + 9 > CTL_W) ? PWM_BITS + 9 : CTL_W) + 1;

   // configuration registers
   logic [PWM_BITS-1:0] base_speed_ff;
   gain_type            prop_gain_ff;
   gain_type            deriv_gain_ff;
   logic [PWM_BITS-1:0] pwm_max_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff <= RST_BASE_SPEED[PWM_BITS-1:0];
         prop_gain_ff  <= RST_PROP_GAIN;
         deriv_gain_ff <= RST_DERIV_GAIN;
         pwm_max_ff    <= RST_PWM_MAX[PWM_BITS-1:0];
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_BASE_SPEED: base_speed_ff <= csr_if.data[PWM_BITS-1:0];
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_if.data;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_if.data;
            CSR_PWM_MAX:    pwm_max_ff    <= csr_if.data[PWM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s1_adv, req_acc;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_acc      = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample register
   line_type s1_line_ff;
   logic     s1_side_a_ff, s1_side_b_ff, s1_hold_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_line_ff   <= req_if.line_bits;
         s1_side_a_ff <= req_if.side_sensor_a;
         s1_side_b_ff <= req_if.side_sensor_b;
         s1_hold_ff   <= req_if.junction_hold;
      end
   end

   // PD math
   pos_type                 last_pos_ff, last_pos_in;
   pos_type                 pos;
   logic signed [4:0]       err;
   logic signed [20:0]      p_term;
   logic signed [21:0]      d_term;
   logic signed [CTL_W-1:0] ctl;
   logic signed [SUM_W-1:0] base_x256, sum_a, sum_b;
   logic [PWM_BITS-1:0]     pd_a, pd_b;
   steer_mode_type          mode;
   logic [PWM_BITS-1:0]     mot_a, mot_b;

   function automatic logic [PWM_BITS-1:0] saturate(logic signed [SUM_W-1:0] val,
                                                    logic [PWM_BITS-1:0] lim);
      logic [SUM_W-9:0] whole;
      logic [PWM_BITS-1:0] res;
      // for val > 0 the shift truncates toward zero; zero and negative sums give 0
      whole = val[SUM_W-1:8];
      if (val[SUM_W-1] || val == '0)
         res = '0;
      else if (whole > {{(SUM_W-8-PWM_BITS){1'b0}}, lim})
         res = lim;
      else
         res = whole[PWM_BITS-1:0];
      return res;
   endfunction

   always_comb begin
      pos       = map_position(s1_line_ff, s1_hold_ff, last_pos_ff);
      err       = {last_pos_ff[POS_W-1], last_pos_ff} - {pos[POS_W-1], pos};
      p_term    = 21'(pos) * 21'($signed({1'b0, prop_gain_ff}));
      d_term    = 22'($signed({1'b0, deriv_gain_ff})) * 22'(err);
      ctl       = CTL_W'(p_term) - CTL_W'(d_term);
      base_x256 = $signed({{(SUM_W-PWM_BITS-8){1'b0}}, base_speed_ff, 8'b0});
      sum_a     = base_x256 - SUM_W'(ctl);
      sum_b     = base_x256 + SUM_W'(ctl);
      pd_a      = saturate(sum_a, pwm_max_ff);
      pd_b      = saturate(sum_b, pwm_max_ff);
   end

   always_comb begin
      last_pos_in = last_pos_ff;
      if (s1_side_a_ff && !s1_side_b_ff) begin
         mode  = MODE_VEER_A;
         mot_a = PWM_VEER_LOW[PWM_BITS-1:0];
         mot_b = PWM_VEER_HIGH[PWM_BITS-1:0];
      end else if (s1_side_b_ff && !s1_side_a_ff) begin
         mode  = MODE_VEER_B;
         mot_a = PWM_VEER_HIGH[PWM_BITS-1:0];
         mot_b = PWM_VEER_LOW[PWM_BITS-1:0];
      end else if (!s1_side_a_ff && !s1_side_b_ff) begin
         mode  = MODE_STRAIGHT;
         mot_a = PWM_STRAIGHT[PWM_BITS-1:0];
         mot_b = PWM_STRAIGHT[PWM_BITS-1:0];
      end else begin
         mode  = MODE_PD;
         mot_a = pd_a;
         mot_b = pd_b;
         if (s1_adv)
            last_pos_in = pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         last_pos_ff <= '0;
      else
         last_pos_ff <= last_pos_in;
   end

   // result register
   logic [PWM_BITS-1:0] rsp_a_ff, rsp_b_ff;
   steer_mode_type      rsp_mode_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_a_ff    <= mot_a;
         rsp_b_ff    <= mot_b;
         rsp_mode_ff <= mode;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.motor_a_pwm = rsp_a_ff;
   assign rsp_if.motor_b_pwm = rsp_b_ff;
   assign rsp_if.steer_mode  = rsp_mode_ff;

   // checks
   a_pd_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mode_ff == MODE_PD |->
         rsp_a_ff <= pwm_max_ff && rsp_b_ff <= pwm_max_ff)
      else $error("PD motor value above pwm limit");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      last_pos_ff >= -4'sd6 && last_pos_ff <= 4'sd6)
      else $error("stored position out of range");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_line_ff))
      else $error("stalled sample lost");

   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted item not held in sample stage");

   a_pos_only_pd: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && mode == MODE_PD) |=> $stable(last_pos_ff))
      else $error("position changed outside a PD step");

endmodule
